// ===== design/hcb_pkg.sv =====
// ============================================================================
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ============================================================================
package hcb_pkg;

    localparam int MAX_LEAVES_DEF  = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int CODE_W          = 63;
    localparam int LEN_W           = 6;
    localparam int IN_WEIGHT_W     = 16;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_DROP = 2'd2;

    typedef struct packed {
        logic [7:0]             symbol;
        logic [IN_WEIGHT_W-1:0] weight;
        logic                   last;
    } t_item;

    typedef struct packed {
        logic [7:0]        out_symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [1:0]        status;
        logic              last_out;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_M1,
        S_M2,
        S_M3,
        S_WSTART,
        S_WCHK
    } t_state;

endpackage

// ===== design/huffman_code_builder_top.sv =====
// ============================================================================
// huffman_code_builder_top
// Loads symbol/weight beats, builds a Huffman tree in node memories and
// emits one code beat per leaf, in load order (one status beat for a set of fewer than two leaves).
// ============================================================================
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+----------------
//  item      | in        | start high, busy low       | i_item (t_item)
//  result    | out       | o_valid strobe, one cycle  | o_result (t_result)
//
//  A beat without last stores (or drops) the leaf and leaves the block idle.
//  After a last beat with n leaves, each of the n-1 merges scans the m nodes
//  created so far through the parent/weight memories, one node a cycle
//  (registered read, then a closing check), and writes back in S_M1, S_M2
//  and S_M3; then each leaf takes a start state, one parent read per code
//  bit and a final check.
//  Reset (synchronous, active low) clears control state only; the memories
//  need no clearing since every entry read is written first in the same set.
//  The receiver cannot stall: a result is shown for exactly one cycle.
//
module huffman_code_builder_top
    import hcb_pkg::*;
#(
    parameter int MAX_LEAVES  = MAX_LEAVES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    localparam int NODES = 2 * MAX_LEAVES - 1;
    localparam int IW    = $clog2(2 * MAX_LEAVES);       // node index width
    localparam int LW    = $clog2(MAX_LEAVES);           // leaf index width
    localparam int CW    = $clog2(MAX_LEAVES + 1);       // leaf count width
    localparam int WW    = WEIGHT_BITS + LW;             // node weight width
    localparam int EW    = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
    localparam logic [IW-1:0] NO_PARENT = {IW{1'b1}};

    // parent entry: {right-child side, parent index}
    logic [IW:0]      parent_mem [0:NODES-1];
    logic [WW-1:0]    weight_mem [0:NODES-1];
    logic [7:0]       sym_mem    [0:MAX_LEAVES-1];

    logic [IW:0]      r_pdata;
    logic [WW-1:0]    r_wdata;
    logic [7:0]       r_sdata;

    // memory port controls
    logic [IW-1:0]    p_raddr, w_raddr;
    logic [LW-1:0]    s_raddr;
    logic             p_we, w_we, s_we;
    logic [IW-1:0]    p_waddr, w_waddr;
    logic [LW-1:0]    s_waddr;
    logic [IW:0]      p_wdat;
    logic [WW-1:0]    w_wdat;
    logic [7:0]       s_wdat;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [IW-1:0]    r_n, n_n;
    logic [IW-1:0]    r_new, n_new;
    logic [IW-1:0]    r_scan_i, n_scan_i;
    logic             r_pend, n_pend;
    logic [IW-1:0]    r_pend_id, n_pend_id;
    logic             r_h1, n_h1, r_h2, n_h2;
    logic [IW-1:0]    r_a, n_a, r_b, n_b;
    logic [WW-1:0]    r_wa, n_wa, r_wb, n_wb;
    logic [1:0]       r_status, n_status;
    logic [IW-1:0]    r_k, n_k;
    logic [IW-1:0]    r_cur, n_cur;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CODE_W-1:0] r_code, n_code;
    logic             r_ovalid, n_ovalid;
    t_result          r_out, n_out;

    logic             accept;
    logic [CW-1:0]    final_n;
    logic [IW-1:0]    total;
    logic [IW-1:0]    p_parent;
    logic             p_side;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_result = r_out;
    assign total    = (r_n << 1) - IW'(1);
    assign p_parent = r_pdata[IW-1:0];
    assign p_side   = r_pdata[IW];
    assign final_n  = (r_count < CW'(MAX_LEAVES)) ? r_count + CW'(1) : r_count;

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            parent_mem[p_waddr] <= p_wdat;
        end
        if (w_we) begin
            weight_mem[w_waddr] <= w_wdat;
        end
        if (s_we) begin
            sym_mem[s_waddr] <= s_wdat;
        end
        r_pdata <= parent_mem[p_raddr];
        r_wdata <= weight_mem[w_raddr];
        r_sdata <= sym_mem[s_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload and working registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_new     <= n_new;
        r_scan_i  <= n_scan_i;
        r_pend_id <= n_pend_id;
        r_h1      <= n_h1;
        r_h2      <= n_h2;
        r_a       <= n_a;
        r_b       <= n_b;
        r_wa      <= n_wa;
        r_wb      <= n_wb;
        r_status  <= n_status;
        r_k       <= n_k;
        r_cur     <= n_cur;
        r_len     <= n_len;
        r_code    <= n_code;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_n       = r_n;
        n_new     = r_new;
        n_scan_i  = r_scan_i;
        n_pend    = 1'b0;
        n_pend_id = r_pend_id;
        n_h1      = r_h1;
        n_h2      = r_h2;
        n_a       = r_a;
        n_b       = r_b;
        n_wa      = r_wa;
        n_wb      = r_wb;
        n_status  = r_status;
        n_k       = r_k;
        n_cur     = r_cur;
        n_len     = r_len;
        n_code    = r_code;
        n_ovalid  = 1'b0;
        n_out     = r_out;

        p_raddr = r_cur;
        w_raddr = r_scan_i;
        s_raddr = r_k[LW-1:0];
        p_we    = 1'b0;
        w_we    = 1'b0;
        s_we    = 1'b0;
        p_waddr = IW'(r_count);
        w_waddr = IW'(r_count);
        s_waddr = r_count[LW-1:0];
        p_wdat  = {1'b0, NO_PARENT};
        w_wdat  = WW'(i_item.weight[EW-1:0]);
        s_wdat  = i_item.symbol;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // Store the leaf, or drop it and flag when the table is full.
                    if (r_count < CW'(MAX_LEAVES)) begin
                        p_we    = 1'b1;
                        w_we    = 1'b1;
                        s_we    = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        if (final_n < CW'(2)) begin
                            n_ovalid          = 1'b1;
                            n_out.out_symbol  = '0;
                            n_out.code_bits   = '0;
                            n_out.code_length = '0;
                            n_out.status      = ST_FEW;
                            n_out.last_out    = 1'b1;
                        end else begin
                            n_n      = IW'(final_n);
                            n_new    = IW'(final_n);
                            n_status = (r_ovf || !(r_count < CW'(MAX_LEAVES)))
                                       ? ST_DROP : ST_OK;
                            n_scan_i = '0;
                            n_h1     = 1'b0;
                            n_h2     = 1'b0;
                            n_state  = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Issue one node read a cycle; judge the node read last cycle.
                p_raddr = r_scan_i;
                if (r_scan_i < r_new) begin
                    n_scan_i  = r_scan_i + IW'(1);
                    n_pend    = 1'b1;
                    n_pend_id = r_scan_i;
                end
                if (r_pend && (p_parent == NO_PARENT)) begin
                    if (!r_h1 || (r_wdata < r_wa)) begin
                        if (r_h1) begin
                            n_b  = r_a;
                            n_wb = r_wa;
                            n_h2 = 1'b1;
                        end
                        n_a  = r_pend_id;
                        n_wa = r_wdata;
                        n_h1 = 1'b1;
                    end else if (!r_h2 || (r_wdata < r_wb)) begin
                        n_b  = r_pend_id;
                        n_wb = r_wdata;
                        n_h2 = 1'b1;
                    end
                end
                if (!r_pend && (r_scan_i == r_new)) begin
                    n_state = S_M1;
                end
            end
            S_M1: begin
                p_we    = 1'b1;
                p_waddr = r_a;
                p_wdat  = {1'b0, r_new};
                n_state = S_M2;
            end
            S_M2: begin
                p_we    = 1'b1;
                p_waddr = r_b;
                p_wdat  = {1'b1, r_new};
                w_we    = 1'b1;
                w_waddr = r_new;
                w_wdat  = r_wa + r_wb;
                n_state = S_M3;
            end
            S_M3: begin
                // Mark the new node parentless, then scan again or start walking.
                p_we    = 1'b1;
                p_waddr = r_new;
                p_wdat  = {1'b0, NO_PARENT};
                n_new   = r_new + IW'(1);
                if (n_new == total) begin
                    n_k     = '0;
                    n_state = S_WSTART;
                end else begin
                    n_scan_i = '0;
                    n_h1     = 1'b0;
                    n_h2     = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_WSTART: begin
                p_raddr = r_k;
                n_cur   = r_k;
                n_len   = '0;
                n_code  = '0;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if ((p_parent == NO_PARENT) || (r_len == LEN_W'(CODE_W))) begin
                    n_ovalid          = 1'b1;
                    n_out.out_symbol  = r_sdata;
                    n_out.code_bits   = r_code;
                    n_out.code_length = r_len;
                    n_out.status      = r_status;
                    n_out.last_out    = (r_k == r_n - IW'(1));
                    if (r_k == r_n - IW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_WSTART;
                    end
                end else begin
                    // Advance one step toward the root.
                    n_code  = r_code | (CODE_W'(p_side) << r_len);
                    n_len   = r_len + LEN_W'(1);
                    n_cur   = p_parent;
                    p_raddr = p_parent;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A short-set status beat always closes its set.
    a_few_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result.status == ST_FEW)) |-> o_result.last_out)
        else $error("status beat without last_out");

    // After the final beat of a set the block is free again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_out) |-> !busy)
        else $error("busy after final beat");

    // Merges never run past the last node of the tree.
    a_new_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_new < total))
        else $error("merge index past tree size");

endmodule

// ===== dv/huffman_code_builder_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman code builder testbench
// Feeds symbol/weight sets through the item port, predicts the code of
// every leaf with a software tree build and checks each result beat in order.
// ----------------------------------------------------------------------------
module huffman_code_builder_top_test;
    import hcb_pkg::*;

    localparam int NODES     = 2 * MAX_LEAVES_DEF - 1;
    localparam int NO_PARENT = 127;
    localparam int WDOG_MAX  = 200000;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    huffman_code_builder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor copy of the block's set under construction.
    logic [7:0]  set_symbols[MAX_LEAVES_DEF];
    logic [21:0] tree_weight[NODES];
    int          tree_parent[NODES];
    int          tree_left[NODES];
    int          set_leaves;
    bit          set_dropped;

    t_item   pending_items[$];
    t_result expected_codes[$];
    int      errors;
    int      beats_in;
    int      beats_out;
    int      sets_built;

    // Fold one accepted beat into the predicted set; on last, build the tree
    // and queue one code per leaf in load order (one status beat below two leaves).
    task automatic predict_codes(input t_item it);
        int      n;
        int      a;
        int      b;
        int      c;
        int      f;
        int      len;
        bit      h1;
        bit      h2;
        logic [62:0] code;
        logic [1:0]  st;
        t_result r;
        if (set_leaves < MAX_LEAVES_DEF) begin
            set_symbols[set_leaves] = it.symbol;
            tree_weight[set_leaves] = 22'(it.weight);
            set_leaves++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!it.last) return;
        n = set_leaves;
        st = set_dropped ? ST_DROP : ST_OK;
        set_leaves = 0;
        set_dropped = 1'b0;
        sets_built++;
        if (n < 2) begin
            r = '0;
            r.status = ST_FEW;
            r.last_out = 1'b1;
            expected_codes.push_back(r);
            return;
        end
        for (int i = 0; i < 2 * n - 1; i++) begin
            tree_parent[i] = NO_PARENT;
            tree_left[i] = 0;
        end
        for (int i = n; i < 2 * n - 1; i++) begin
            h1 = 0;
            h2 = 0;
            a = 0;
            b = 0;
            for (int j = 0; j < i; j++) begin
                if (tree_parent[j] != NO_PARENT) continue;
                if (!h1 || tree_weight[j] < tree_weight[a]) begin
                    if (h1) begin
                        b = a;
                        h2 = 1;
                    end
                    a = j;
                    h1 = 1;
                end else if (!h2 || tree_weight[j] < tree_weight[b]) begin
                    b = j;
                    h2 = 1;
                end
            end
            tree_parent[a] = i;
            tree_parent[b] = i;
            tree_left[i] = a;
            tree_weight[i] = tree_weight[a] + tree_weight[b];
        end
        for (int k = 0; k < n; k++) begin
            c = k;
            f = tree_parent[c];
            code = '0;
            len = 0;
            while (f != NO_PARENT && len < 63) begin
                if (tree_left[f] != c) code[len] = 1'b1;
                len++;
                c = f;
                f = tree_parent[c];
            end
            r.out_symbol = set_symbols[k];
            r.code_bits = code;
            r.code_length = 6'(len);
            r.status = st;
            r.last_out = (k == n - 1);
            expected_codes.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                           : $urandom_range(0, 2);
    endfunction

    // Driver: hold a beat until busy is low at the edge, then advance.
    int  gap_left;
    bit  no_gaps;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                predict_codes(i_item);
                beats_in++;
                void'(pending_items.pop_front());
                gap_left = no_gaps ? 0 : pick_gap();
            end
            if (!(start && busy)) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    start <= 1'b0;
                end else begin
                    start <= 1'b1;
                    i_item <= pending_items[0];
                end
            end
        end
    end

    // Monitor: compare every strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            beats_out++;
            if (expected_codes.size() == 0) begin
                $error("unexpected result beat: %p", o_result);
                errors++;
            end else begin
                want = expected_codes.pop_front();
                if (o_result.out_symbol !== want.out_symbol) begin
                    $error("out_symbol exp %0h got %0h", want.out_symbol,
                           o_result.out_symbol);
                    errors++;
                end
                if (o_result.code_bits !== want.code_bits) begin
                    $error("code_bits exp %0h got %0h", want.code_bits,
                           o_result.code_bits);
                    errors++;
                end
                if (o_result.code_length !== want.code_length) begin
                    $error("code_length exp %0d got %0d", want.code_length,
                           o_result.code_length);
                    errors++;
                end
                if (o_result.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_result.status);
                    errors++;
                end
                if (o_result.last_out !== want.last_out) begin
                    $error("last_out exp %0d got %0d", want.last_out,
                           o_result.last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: during a build of 64 leaves nothing is accepted and no result
    // is shown; idle_cycles counts such stretches against WDOG_MAX.
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_item mk(input int sym, input int w, input bit lst);
        t_item it;
        it.symbol = 8'(sym);
        it.weight = 16'(w);
        it.last = lst;
        return it;
    endfunction

    // Queue a well-formed set of n leaves with random symbols and weights.
    task automatic queue_set(input int n, input int wmax);
        for (int i = 0; i < n; i++)
            pending_items.push_back(mk($urandom_range(0, 255),
                                       $urandom_range(0, wmax), i == n - 1));
    endtask

    initial begin
        int n;
        errors = 0;
        beats_in = 0;
        beats_out = 0;
        sets_built = 0;
        set_leaves = 0;
        set_dropped = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: lone symbol, two symbols at the extremes, equal and zero
        // weights, a set that runs past the leaf limit.
        pending_items.push_back(mk(8'hFF, 16'hFFFF, 1));
        pending_items.push_back(mk(8'h00, 0, 0));
        pending_items.push_back(mk(8'hFF, 16'hFFFF, 1));
        pending_items.push_back(mk(8'h55, 7, 0));
        pending_items.push_back(mk(8'hAA, 7, 0));
        pending_items.push_back(mk(8'h0F, 7, 0));
        pending_items.push_back(mk(8'hF0, 0, 1));
        pending_items.push_back(mk(8'h12, 0, 0));
        pending_items.push_back(mk(8'h34, 0, 1));
        for (int i = 0; i < 66; i++)
            pending_items.push_back(mk(i, 16'hFFFF - i, i == 65));

        // Random: mostly small sets, a few large ones, some lone symbols.
        while (pending_items.size() < 180) begin
            case ($urandom_range(0, 9))
                0: n = 1;
                1: n = $urandom_range(40, 64);
                default: n = $urandom_range(2, 12);
            endcase
            queue_set(n, ($urandom_range(0, 1) ? 16'hFFFF : 15));
        end

        // Run the tail with no gaps to cover back-to-back beats.
        wait (pending_items.size() < 40);
        no_gaps = 1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (start) @(posedge i_clk);
        while (expected_codes.size() != 0 || busy) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("covered %0d beats in, %0d sets built, %0d code beats checked",
                 beats_in, sets_built, beats_out);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
